// ----- src/buddy_block_allocator_top_defines.svh -----
// Assertion macros for the buddy block allocator.
// Used by buddy_block_allocator_top; no other dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BBA_ASSERT_SAME(lbl, clk, rst_n, a, c)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- src/bba_pkg.sv -----
// Shared types and constants for the buddy block allocator.
// No dependencies.
package bba_pkg;

    localparam int DEF_TOTAL_ORDER  = 14;
    localparam int DEF_MIN_ORDER    = 5;
    localparam int DEF_HEADER_BYTES = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_POP,
        S_SPLIT_CHK,
        S_SPLIT_PUSH,
        S_PUSHF,
        S_FCHK,
        S_FHEAD,
        S_MRD,
        S_MCHK,
        S_RSCAN,
        S_RCMP,
        S_RSHIFT,
        S_RMOVE,
        S_MUPD
    } t_state;

endpackage

// ----- src/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/buddy_block_allocator_top.sv -----
// Buddy block allocator: sequencer, free counts and granule/stack RAMs.
// Depends on bba_pkg, bba_ram and buddy_block_allocator_top_defines.svh.
//
// Usage:
//   Command channel: raise start with i_opcode, i_request_bytes and
//   i_free_address while busy is low; the beat is taken at that edge.
//   Result channel: o_done strobes for one cycle with o_data_address and
//   o_status. The receiver cannot stall; the result is simply presented.
//   Configuration: i_cfg_valid/o_cfg_ready write the pool base address;
//   ready is always high. Write only while the block is idle.
//   Reset: a clearing pass sweeps all 2^(TOTAL_ORDER-MIN_ORDER) granules
//   (512 by default), one granule a cycle, with busy high.
//   One shared datapath serves all commands. Allocate searches the orders
//   upward, pops a fitting block and splits it down while the half still
//   fits; a failed search ends at the top order. Free checks the address
//   and head, then merges level by level up to the top order, scanning and
//   shifting stack entries to remove each buddy; a bad free address fails.
//   The result strobes in the first cycle with busy low; a new command may
//   be given in that same cycle.
`include "buddy_block_allocator_top_defines.svh"
module buddy_block_allocator_top #(
    parameter int TOTAL_ORDER  = bba_pkg::DEF_TOTAL_ORDER,
    parameter int MIN_ORDER    = bba_pkg::DEF_MIN_ORDER,
    parameter int HEADER_BYTES = bba_pkg::DEF_HEADER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [14:0] i_request_bytes,
    input  logic [31:0] i_free_address,
    output logic        o_done,
    output logic [31:0] o_data_address,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int GW     = TOTAL_ORDER - MIN_ORDER;
    localparam int G      = 1 << GW;
    localparam int ORDERS = GW + 1;
    localparam int OW     = $clog2(ORDERS);
    localparam int CW     = GW + 1;
    localparam int EW     = OW + 2;
    localparam int SAW    = $clog2(ORDERS * G);
    localparam int CMPW   = (TOTAL_ORDER + 1 > 16) ? TOTAL_ORDER + 1 : 16;
    localparam logic [OW-1:0] TOP_IDX = OW'(ORDERS - 1);
    localparam logic [CW-1:0] G_CNT   = CW'(G);

    bba_pkg::t_state r_state, n_state;

    logic [GW-1:0]   r_clr;
    logic [CW-1:0]   r_cnt [ORDERS];
    logic [31:0]     r_base;
    logic [14:0]     r_req;
    logic [31:0]     r_fa;
    logic [OW-1:0]   r_ord;
    logic [GW-1:0]   r_g;
    logic [CW-1:0]   r_k;
    logic            r_done;
    logic [31:0]     r_addr;
    logic            r_status;

    logic            g_we;
    logic [GW-1:0]   g_waddr, g_raddr;
    logic [EW-1:0]   g_wdata, g_rdata;
    logic            s_we;
    logic [OW+GW-1:0] s_wfull, s_rfull;
    logic [GW-1:0]   s_wdata, s_rdata;

    logic [CW-1:0]   cnt_sel, cnt_m1, k_p1;
    logic [OW-1:0]   cap_ord;
    logic [CMPW-1:0] cap;
    logic            fits;
    logic [GW-1:0]   ord_bit, buddy;
    logic [31:0]     rel;
    logic            rel_bad;
    logic [OW-1:0]   gr_ord;
    logic            gr_free, gr_head;
    logic            head_bad;

    bba_ram #(.WIDTH(EW), .DEPTH(G)) u_gran (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    bba_ram #(.WIDTH(GW), .DEPTH(ORDERS * G)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_wfull[SAW-1:0]),
        .i_wdata (s_wdata),
        .i_raddr (s_rfull[SAW-1:0]),
        .o_rdata (s_rdata)
    );

    assign cnt_sel = r_cnt[r_ord];
    assign cnt_m1  = cnt_sel - CW'(1);
    assign k_p1    = r_k + CW'(1);
    assign cap     = ({{(CMPW-1){1'b0}}, 1'b1} << (32'(cap_ord) + MIN_ORDER))
                     - CMPW'(HEADER_BYTES);
    assign fits    = {{(CMPW-15){1'b0}}, r_req} <= cap;
    assign ord_bit = GW'(1) << r_ord;
    assign buddy   = r_g ^ ord_bit;
    assign rel     = r_fa - 32'(HEADER_BYTES) - r_base;
    assign rel_bad = (rel[31:TOTAL_ORDER] != '0) || (rel[MIN_ORDER-1:0] != '0);
    assign gr_ord  = g_rdata[EW-1:2];
    assign gr_free = g_rdata[1];
    assign gr_head = g_rdata[0];
    assign head_bad = !gr_head || gr_free || (gr_ord > TOP_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        g_we    = 1'b0;
        g_waddr = r_g;
        g_wdata = '0;
        g_raddr = r_g;
        s_we    = 1'b0;
        s_wfull = {r_ord, r_g};
        s_wdata = r_g;
        s_rfull = {r_ord, r_k[GW-1:0]};
        cap_ord = r_ord;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                g_we    = 1'b1;
                g_waddr = r_clr;
                g_wdata = (r_clr == '0) ? {TOP_IDX, 1'b1, 1'b1} : '0;
                s_we    = (r_clr == '0);
                s_wfull = {TOP_IDX, {GW{1'b0}}};
                s_wdata = '0;
                if (r_clr == GW'(G - 1)) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (start) begin
                    n_state = (i_opcode == bba_pkg::OP_ALLOC) ? bba_pkg::S_SEARCH
                                                             : bba_pkg::S_FCHK;
                end
            end
            bba_pkg::S_SEARCH: begin
                s_rfull = {r_ord, cnt_m1[GW-1:0]};
                if (cnt_sel != '0 && fits) begin
                    n_state = bba_pkg::S_POP;
                end else if (r_ord == TOP_IDX) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_POP: begin
                n_state = bba_pkg::S_SPLIT_CHK;
            end
            bba_pkg::S_SPLIT_CHK: begin
                cap_ord = r_ord - OW'(1);
                if (r_ord != '0 && fits) begin
                    n_state = bba_pkg::S_SPLIT_PUSH;
                end else begin
                    g_we    = 1'b1;
                    g_wdata = {r_ord, 1'b0, 1'b1};
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_SPLIT_PUSH, bba_pkg::S_PUSHF: begin
                g_we    = 1'b1;
                g_wdata = {r_ord, 1'b1, 1'b1};
                s_we    = cnt_sel < G_CNT;
                s_wfull = {r_ord, cnt_sel[GW-1:0]};
                n_state = (r_state == bba_pkg::S_SPLIT_PUSH) ? bba_pkg::S_SPLIT_CHK
                                                             : bba_pkg::S_IDLE;
            end
            bba_pkg::S_FCHK: begin
                g_raddr = rel[TOTAL_ORDER-1:MIN_ORDER];
                n_state = rel_bad ? bba_pkg::S_IDLE : bba_pkg::S_FHEAD;
            end
            bba_pkg::S_FHEAD: begin
                n_state = head_bad ? bba_pkg::S_IDLE : bba_pkg::S_MRD;
            end
            bba_pkg::S_MRD: begin
                g_raddr = buddy;
                n_state = (r_ord == TOP_IDX) ? bba_pkg::S_PUSHF : bba_pkg::S_MCHK;
            end
            bba_pkg::S_MCHK: begin
                if (gr_head && gr_free && gr_ord == r_ord) begin
                    n_state = bba_pkg::S_RSCAN;
                end else begin
                    n_state = bba_pkg::S_PUSHF;
                end
            end
            bba_pkg::S_RSCAN: begin
                n_state = (r_k == cnt_sel) ? bba_pkg::S_MUPD : bba_pkg::S_RCMP;
            end
            bba_pkg::S_RCMP: begin
                n_state = (s_rdata == buddy) ? bba_pkg::S_RSHIFT : bba_pkg::S_RSCAN;
            end
            bba_pkg::S_RSHIFT: begin
                s_rfull = {r_ord, k_p1[GW-1:0]};
                n_state = (k_p1 < cnt_sel) ? bba_pkg::S_RMOVE : bba_pkg::S_MUPD;
            end
            bba_pkg::S_RMOVE: begin
                s_we    = 1'b1;
                s_wfull = {r_ord, r_k[GW-1:0]};
                s_wdata = s_rdata;
                n_state = bba_pkg::S_RSHIFT;
            end
            bba_pkg::S_MUPD: begin
                g_we    = 1'b1;
                g_waddr = r_g | ord_bit;
                g_wdata = '0;
                n_state = bba_pkg::S_MRD;
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_base <= '0;
            r_done <= 1'b0;
            for (int i = 0; i < ORDERS; i++) begin
                r_cnt[i] <= (i == ORDERS - 1) ? CW'(1) : '0;
            end
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            case (r_state)
                bba_pkg::S_CLEAR: begin
                    r_clr <= r_clr + GW'(1);
                end
                bba_pkg::S_IDLE: begin
                    if (start) begin
                        r_req <= i_request_bytes;
                        r_fa  <= i_free_address;
                        r_ord <= '0;
                    end
                end
                bba_pkg::S_SEARCH: begin
                    if (cnt_sel != '0 && fits) begin
                        r_cnt[r_ord] <= cnt_m1;
                    end else if (r_ord == TOP_IDX) begin
                        r_done   <= 1'b1;
                        r_addr   <= '0;
                        r_status <= bba_pkg::ST_FAIL;
                    end else begin
                        r_ord <= r_ord + OW'(1);
                    end
                end
                bba_pkg::S_POP: begin
                    r_g <= s_rdata;
                end
                bba_pkg::S_SPLIT_CHK: begin
                    if (r_ord != '0 && fits) begin
                        r_ord <= r_ord - OW'(1);
                    end else begin
                        r_done   <= 1'b1;
                        r_addr   <= r_base + (32'(r_g) << MIN_ORDER) + 32'(HEADER_BYTES);
                        r_status <= bba_pkg::ST_OK;
                    end
                end
                bba_pkg::S_SPLIT_PUSH: begin
                    if (cnt_sel < G_CNT) begin
                        r_cnt[r_ord] <= cnt_sel + CW'(1);
                    end
                    r_g <= r_g + ord_bit;
                end
                bba_pkg::S_PUSHF: begin
                    if (cnt_sel < G_CNT) begin
                        r_cnt[r_ord] <= cnt_sel + CW'(1);
                    end
                    r_done   <= 1'b1;
                    r_addr   <= '0;
                    r_status <= bba_pkg::ST_OK;
                end
                bba_pkg::S_FCHK: begin
                    r_g <= rel[TOTAL_ORDER-1:MIN_ORDER];
                    if (rel_bad) begin
                        r_done   <= 1'b1;
                        r_addr   <= '0;
                        r_status <= bba_pkg::ST_FAIL;
                    end
                end
                bba_pkg::S_FHEAD: begin
                    if (head_bad) begin
                        r_done   <= 1'b1;
                        r_addr   <= '0;
                        r_status <= bba_pkg::ST_FAIL;
                    end else begin
                        r_ord <= gr_ord;
                    end
                end
                bba_pkg::S_MCHK: begin
                    r_k <= '0;
                end
                bba_pkg::S_RCMP: begin
                    if (s_rdata != buddy) begin
                        r_k <= k_p1;
                    end
                end
                bba_pkg::S_RSHIFT: begin
                    if (!(k_p1 < cnt_sel)) begin
                        r_cnt[r_ord] <= cnt_m1;
                    end
                end
                bba_pkg::S_RMOVE: begin
                    r_k <= k_p1;
                end
                bba_pkg::S_MUPD: begin
                    r_g   <= r_g & ~ord_bit;
                    r_ord <= r_ord + OW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign busy           = (r_state != bba_pkg::S_IDLE);
    assign o_done         = r_done;
    assign o_data_address = r_addr;
    assign o_status       = r_status;
    assign o_cfg_ready    = 1'b1;

    `BBA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `BBA_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `BBA_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_done && o_status, o_data_address == '0)

endmodule
